@@ rtl/scfp_pkg.sv @@
`timescale 1ns / 1ps

package scfp_pkg;

    localparam int PARAM_WORDS  = 10;
    localparam int PAYLOAD_LEN  = 40;
    localparam int PAYLOAD_ROWS = PAYLOAD_LEN / 4;
    localparam int ROW_AW       = $clog2(PAYLOAD_ROWS);
    localparam int CNT_W        = 6;
    localparam int WIDX_W       = 4;

    localparam logic [WIDX_W-1:0] LAST_WORD_IDX = WIDX_W'(PARAM_WORDS - 1);
    localparam logic [CNT_W-1:0]  PAYLOAD_CNT   = CNT_W'(PAYLOAD_LEN);
    localparam logic [CNT_W-1:0]  BLOCK_CNT     = CNT_W'(2);

    // Command and framing bytes.
    localparam logic [7:0] CMD_SEND_PARAMS = 8'h30;
    localparam logic [7:0] CMD_BLOCK_UP    = 8'h33;
    localparam logic [7:0] CMD_BLOCK_DOWN  = 8'h34;
    localparam logic [7:0] CMD_BLOCK_JUMP  = 8'h35;
    localparam logic [7:0] BLOCK_END       = 8'h36;
    localparam logic [7:0] PAYLOAD_PRE     = 8'hAA;
    localparam logic [7:0] PAYLOAD_START   = 8'hAF;
    localparam logic [7:0] PAYLOAD_END     = 8'hAB;
    localparam logic [7:0] SAVE_PRE        = 8'hAC;
    localparam logic [7:0] SAVE_START      = 8'hAD;

    // Result event codes.
    localparam logic [1:0] EV_WORD        = 2'd0;
    localparam logic [1:0] EV_SEND_PARAMS = 2'd1;
    localparam logic [1:0] EV_SEND_BLOCK  = 2'd2;
    localparam logic [1:0] EV_SAVE        = 2'd3;

    typedef struct packed {
        logic              accept;
        logic              load_single;
        logic              rd_en;
        logic              load_word;
        logic              load_params;
        logic [WIDX_W-1:0] word_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic       emit;
        logic [1:0] ev;
        logic       words;
    } t_dp_status;

endpackage

@@ rtl/scfp_datapath.sv @@
`timescale 1ns / 1ps

module scfp_datapath
    import scfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic [1:0]        o_event_res,
    output logic [WIDX_W-1:0] o_word_index,
    output logic [31:0]       o_word_value,
    output logic [15:0]       o_block_number,
    output logic              o_last
);

    logic              r_storage_ready;
    logic [7:0]        r_prev;
    logic [CNT_W-1:0]  r_count;
    logic              r_in_payload;
    logic              r_in_block;
    logic [7:0]        r_blk_lo;
    logic [7:0]        r_blk_hi;
    logic [15:0]       r_block;

    logic [CNT_W-1:0]  n_count;
    logic              n_in_payload;
    logic              n_in_block;
    logic [15:0]       n_block;
    logic              store_payload;
    logic              store_block;
    t_dp_status        status;

    logic [31:0]       mem [PAYLOAD_ROWS];
    logic [ROW_AW-1:0] wr_row;
    logic [1:0]        wr_lane;
    logic [31:0]       r_rd_data;
    logic              rd_in_range;

    logic [1:0]        r_event;
    logic [WIDX_W-1:0] r_widx;
    logic [31:0]       r_wval;
    logic              r_last;

    always_comb begin
        n_count       = r_count;
        n_in_payload  = r_in_payload;
        n_in_block    = r_in_block;
        n_block       = r_block;
        store_payload = 1'b0;
        store_block   = 1'b0;
        status        = '{emit: 1'b0, ev: EV_SEND_BLOCK, words: 1'b0};
        if (r_in_payload) begin
            if (r_count < PAYLOAD_CNT) begin
                store_payload = 1'b1;
                n_count       = r_count + CNT_W'(1);
            end else begin
                n_count      = '0;
                n_in_payload = 1'b0;
                status.words = (i_rx_byte == PAYLOAD_END);
            end
        end else if (r_in_block) begin
            if (r_count >= BLOCK_CNT) begin
                if (i_rx_byte == BLOCK_END) begin
                    n_block     = {r_blk_hi, r_blk_lo};
                    status.emit = 1'b1;
                end
                n_in_block = 1'b0;
                n_count    = '0;
            end else begin
                store_block = 1'b1;
                n_count     = r_count + CNT_W'(1);
            end
        end else begin
            unique case (i_rx_byte)
                CMD_SEND_PARAMS: begin
                    status.emit = 1'b1;
                    status.ev   = EV_SEND_PARAMS;
                end
                CMD_BLOCK_UP: begin
                    if (r_storage_ready) begin
                        n_block     = r_block + 16'd1;
                        status.emit = 1'b1;
                    end
                end
                CMD_BLOCK_DOWN: begin
                    if (r_storage_ready) begin
                        n_block     = r_block - 16'd1;
                        status.emit = 1'b1;
                    end
                end
                CMD_BLOCK_JUMP: begin
                    if (r_storage_ready) begin
                        n_in_block = 1'b1;
                        n_count    = '0;
                    end
                end
                PAYLOAD_START: begin
                    if (r_prev == PAYLOAD_PRE) begin
                        n_in_payload = 1'b1;
                        n_count      = '0;
                    end
                end
                SAVE_START: begin
                    if (r_prev == SAVE_PRE) begin
                        status.emit = 1'b1;
                        status.ev   = EV_SAVE;
                    end
                end
                default: begin
                    n_block     = '0;
                    status.emit = 1'b1;
                end
            endcase
        end
    end

    assign o_status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_storage_ready <= 1'b0;
            r_prev          <= '0;
            r_count         <= '0;
            r_in_payload    <= 1'b0;
            r_in_block      <= 1'b0;
            r_block         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_storage_ready <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_prev       <= i_rx_byte;
                r_count      <= n_count;
                r_in_payload <= n_in_payload;
                r_in_block   <= n_in_block;
                r_block      <= n_block;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_block) begin
            if (r_count[0]) begin
                r_blk_hi <= i_rx_byte;
            end else begin
                r_blk_lo <= i_rx_byte;
            end
        end
    end

    // Payload is kept as 32-bit rows so one read yields a whole word.
    assign wr_row      = ROW_AW'(r_count >> 2);
    assign wr_lane     = r_count[1:0];
    assign rd_in_range = (int'(i_cmd.word_idx) < PAYLOAD_ROWS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_payload) begin
            mem[wr_row][8*wr_lane +: 8] <= i_rx_byte;
        end
        if (i_cmd.rd_en && rd_in_range) begin
            r_rd_data <= mem[i_cmd.word_idx[ROW_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_event <= status.ev;
            r_widx  <= '0;
            r_wval  <= '0;
            r_last  <= 1'b1;
        end else if (i_cmd.load_word) begin
            r_event <= EV_WORD;
            r_widx  <= i_cmd.word_idx;
            r_wval  <= rd_in_range ? r_rd_data : 32'd0;
            r_last  <= 1'b0;
        end else if (i_cmd.load_params) begin
            r_event <= EV_SEND_PARAMS;
            r_widx  <= '0;
            r_wval  <= '0;
            r_last  <= 1'b1;
        end
    end

    assign o_event_res    = r_event;
    assign o_word_index   = r_widx;
    assign o_word_value   = r_wval;
    assign o_block_number = r_block;
    assign o_last         = r_last;

endmodule

@@ rtl/scfp_controller.sv @@
`timescale 1ns / 1ps

module scfp_controller
    import scfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_WORD   = 2'd2;
    localparam logic [1:0] S_PARAMS = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [WIDX_W-1:0] r_widx;
    logic [WIDX_W-1:0] n_widx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              slot_free;
    logic              accept;
    t_dp_cmd           cmd;

    // The output register can take a new beat when empty or being drained.
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state         = r_state;
        n_widx          = r_widx;
        cmd             = '0;
        cmd.accept      = accept;
        cmd.word_idx    = r_widx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_single = i_status.emit;
                    if (i_status.words) begin
                        n_widx  = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_WORD;
            end
            S_WORD: begin
                if (slot_free) begin
                    cmd.load_word = 1'b1;
                    if (r_widx == LAST_WORD_IDX) begin
                        n_state = S_PARAMS;
                    end else begin
                        n_widx  = r_widx + WIDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_PARAMS: begin
                if (slot_free) begin
                    cmd.load_params = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (cmd.load_single || cmd.load_word || cmd.load_params) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/serial_command_frame_parser.sv @@
`timescale 1ns / 1ps
// A byte is taken when offered and not stalled; its single result, if any, shows
// in the cycle after. A closing 0xAB of a payload frame instead emits ten words
// (each a payload memory read, then an output load that waits for a free output
// slot), then the send-parameters beat; no byte is taken until that beat is loaded.
// Synchronous active-low reset clears frame state, block number and storage_ready.
module serial_command_frame_parser
    import scfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_event_res,
    output logic [WIDX_W-1:0] o_word_index,
    output logic [31:0]       o_word_value,
    output logic [15:0]       o_block_number,
    output logic              o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    scfp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    scfp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_event_res    (o_event_res),
        .o_word_index   (o_word_index),
        .o_word_value   (o_word_value),
        .o_block_number (o_block_number),
        .o_last         (o_last)
    );

endmodule

@@ rtl/scfp_checker.sv @@
`timescale 1ns / 1ps

module scfp_checker
    import scfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_event_res,
    input logic [WIDX_W-1:0] o_word_index,
    input logic [31:0]       o_word_value,
    input logic [15:0]       o_block_number,
    input logic              o_last
);

    // A stalled result beat holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_res)
            && $stable(o_word_index) && $stable(o_word_value)
            && $stable(o_block_number) && $stable(o_last))
    else $error("stalled result beat changed");

    // Parameter words are never the final beat of a byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_WORD) |-> !o_last
            && (o_word_index <= LAST_WORD_IDX))
    else $error("bad parameter word beat");

    // Request beats end their byte and carry no word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != EV_WORD) |-> o_last
            && (o_word_index == '0) && (o_word_value == '0))
    else $error("bad request beat");

    // No new byte is taken while a word burst is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_WORD) |-> o_in_stall)
    else $error("byte taken during word burst");

    // An offered byte waits while a stalled result beat is held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_out_valid && i_out_stall |-> o_in_stall)
    else $error("byte taken while result beat is stalled");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_event_res    (o_event_res),
    .o_word_index   (o_word_index),
    .o_word_value   (o_word_value),
    .o_block_number (o_block_number),
    .o_last         (o_last)
);
